// File: src/pvo_pkg.sv
//------------------------------------------------------------------------------
// pvo_pkg
// Shared constants and types of the percentage volume oscillator.
//------------------------------------------------------------------------------
package pvo_pkg;

	localparam int VOL_W        = 32;
	localparam int OUT_W        = 32;
	localparam int PER_W        = 11;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W        = 2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_FAST   = 2'd0;
	localparam logic [IDX_W-1:0] REG_SLOW   = 2'd1;
	localparam logic [IDX_W-1:0] REG_SIGNAL = 2'd2;

	localparam logic [PER_W-1:0] FAST_RST   = 11'd12;
	localparam logic [PER_W-1:0] SLOW_RST   = 11'd26;
	localparam logic [PER_W-1:0] SIGNAL_RST = 11'd9;
	localparam logic [PER_W-1:0] PERIOD_MAX = 11'd1024;

	typedef struct packed {
		logic signed [OUT_W-1:0] osc_line;
		logic signed [OUT_W-1:0] signal_line;
		logic signed [OUT_W-1:0] histogram;
	} pvo_result_t;

	// Clamp a period register to 1..1024.
	function automatic logic [PER_W-1:0] clamp_period(input logic [PER_W-1:0] p);
		if (p == '0)
			return PER_W'(1);
		else if (p > PERIOD_MAX)
			return PERIOD_MAX;
		else
			return p;
	endfunction

endpackage

// File: src/pvo_if.sv
//------------------------------------------------------------------------------
// pvo_if
// Valid/ready channels: volume input, result output and configuration write.
//------------------------------------------------------------------------------
interface pvo_in_if;
	logic                    valid;
	logic                    ready;
	logic [pvo_pkg::VOL_W-1:0] volume;
	modport source (output valid, output volume, input ready);
	modport sink   (input valid, input volume, output ready);
endinterface

interface pvo_out_if;
	logic                           valid;
	logic                           ready;
	logic signed [pvo_pkg::OUT_W-1:0] osc_line;
	logic signed [pvo_pkg::OUT_W-1:0] signal_line;
	logic signed [pvo_pkg::OUT_W-1:0] histogram;
	modport source (output valid, output osc_line, output signal_line,
		output histogram, input ready);
	modport sink   (input valid, input osc_line, input signal_line,
		input histogram, output ready);
endinterface

interface pvo_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [pvo_pkg::IDX_W-1:0] index;
	logic [pvo_pkg::PER_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/percentage_volume_oscillator.sv
//------------------------------------------------------------------------------
// percentage_volume_oscillator
// Fast/slow volume EMAs, percentage line, signal EMA and histogram.
//------------------------------------------------------------------------------
// Usage:
// in  : one 32-bit unsigned volume word per handshake.
// out : one result word (osc_line, signal_line, histogram), signed Q16.16.
// cfg : writes fast (0), slow (1) and signal (2) periods; other indexes are
//       ignored. Write only while no item is in flight.
// One item is handled at a time. Each EMA step divides 2*|d| by (p+1) in a
// shared restoring bit-serial divider, one quotient bit per cycle, and the
// line is a bit-serial long division of |fast-slow|*100*2^FRAC_BITS by slow.
// The four serial divisions run in turn (fast EMA, slow EMA, line, signal
// EMA) before out.valid rises; the line division is skipped when the slow
// average is zero, and the seed word after reset skips all four. The next
// item is taken while a finished result still waits in the output register,
// so a stalled receiver holds one result plus one finished item and backs up
// the input.
// Reset clears the averages and the seeded flag and loads default periods.
//------------------------------------------------------------------------------
module percentage_volume_oscillator #(
	parameter int FRAC_BITS = pvo_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pvo_in_if.sink    in,
	pvo_out_if.source out,
	pvo_cfg_if.sink   cfg
);
	import pvo_pkg::*;

	localparam int AVG_W = VOL_W + FRAC_BITS;     // unsigned volume averages
	localparam int DW    = AVG_W + 2;             // dividend width (2*|d| plus sign room)
	localparam int SGW   = OUT_W + 2;             // signal average working width
	// Line dividend: |diff| * 100 * 2^F fits AVG_W + 7 + F bits.
	localparam int LW    = AVG_W + 7 + FRAC_BITS;
	localparam int CW    = $clog2(LW + 1);
	localparam int RW    = AVG_W + 1;             // remainder width of line division

	typedef enum logic [3:0] {
		S_IDLE, S_FAST, S_SLOW, S_LPREP, S_LINE, S_LFIN, S_SIG, S_OUT
	} state_t;

	state_t state_q;

	logic [PER_W-1:0] fast_per_q, slow_per_q, sig_per_q;
	logic [AVG_W-1:0] fast_q, slow_q, x_q;
	logic signed [SGW-1:0] sig_q;
	logic seeded_q;

	// Shared serial divider for the EMA steps.
	logic [DW-1:0]    dq_q;      // dividend shifting out, quotient shifting in
	logic [PER_W:0]   drem_q;    // partial remainder
	logic [PER_W:0]   dden_q;    // p+1
	logic             dneg_q;
	logic [CW-1:0]    cnt_q;

	// Line divider.
	logic [LW-1:0]    lq_q;
	logic [RW-1:0]    lrem_q;
	logic             lneg_q;
	logic signed [OUT_W:0] line_q;

	logic             ovalid_q;
	pvo_result_t      res_q;

	logic [PER_W-1:0] pf, ps, pg, pf_eff, ps_eff;
	assign pf = clamp_period(fast_per_q);
	assign ps = clamp_period(slow_per_q);
	assign pg = clamp_period(sig_per_q);
	assign pf_eff = (pf > ps) ? ps : pf;
	assign ps_eff = (pf > ps) ? pf : ps;

	// Divider step: shift one dividend bit into the remainder.
	logic [PER_W+1:0] dtry;
	logic [PER_W+1:0] dsub;
	logic             dfit;
	assign dtry = {drem_q, dq_q[DW-1]};
	assign dsub = dtry - {1'b0, dden_q};
	assign dfit = dtry >= {1'b0, dden_q};

	logic [RW:0]      ltry;
	logic             lfit;
	assign ltry = {lrem_q, lq_q[LW-1]};
	assign lfit = ltry >= {1'b0, slow_q};

	// Setup of an EMA step: magnitude of x-avg and rounding offset preloaded.
	logic [AVG_W:0] dslow;
	logic [AVG_W:0] dfast;
	assign dfast = {1'b0, x_q} - {1'b0, fast_q};
	assign dslow = {1'b0, x_q} - {1'b0, slow_q};

	function automatic logic [DW-1:0] twice_mag(input logic [AVG_W:0] d);
		logic [AVG_W:0] m;
		m = d[AVG_W] ? (~d + 1'b1) : d;
		return {m, 1'b0};
	endfunction

	// q = floor((2|d| + floor(den/2)) / den): the divider adds den/2 up front.
	logic [DW-1:0] quo;
	assign quo = dq_q;

	logic signed [SGW-1:0] sig_d;
	assign sig_d = SGW'(line_q) - sig_q;

	logic signed [SGW-1:0] hist_w;
	assign hist_w = SGW'(line_q) - sig_q;

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [SGW-1:0] v);
		if (v > SGW'(signed'({1'b0, {(OUT_W-1){1'b1}}})))
			return {1'b0, {(OUT_W-1){1'b1}}};
		else if (v < -SGW'(signed'({1'b0, 1'b1, {(OUT_W-1){1'b0}}})))
			return {1'b1, {(OUT_W-1){1'b0}}};
		else
			return v[OUT_W-1:0];
	endfunction

	assign in.ready  = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out.valid       = ovalid_q;
	assign out.osc_line    = res_q.osc_line;
	assign out.signal_line = res_q.signal_line;
	assign out.histogram   = res_q.histogram;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_per_q <= FAST_RST;
			slow_per_q <= SLOW_RST;
			sig_per_q  <= SIGNAL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FAST:   fast_per_q <= cfg.data;
				REG_SLOW:   slow_per_q <= cfg.data;
				REG_SIGNAL: sig_per_q  <= cfg.data;
				default:    ;
			endcase
		end
	end

	// Sequencer with the serial dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			seeded_q <= 1'b0;
			ovalid_q <= 1'b0;
			fast_q   <= '0;
			slow_q   <= '0;
			sig_q    <= '0;
			x_q      <= '0;
			dq_q     <= '0;
			drem_q   <= '0;
			dden_q   <= '0;
			dneg_q   <= 1'b0;
			cnt_q    <= '0;
			lq_q     <= '0;
			lrem_q   <= '0;
			lneg_q   <= 1'b0;
			line_q   <= '0;
			res_q    <= '0;
		end else begin
			// The output register empties when the receiver takes the word.
			if (out.ready && state_q != S_OUT)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in.valid) begin
						x_q <= {in.volume, {FRAC_BITS{1'b0}}};
						if (!seeded_q) begin
							fast_q   <= {in.volume, {FRAC_BITS{1'b0}}};
							slow_q   <= {in.volume, {FRAC_BITS{1'b0}}};
							sig_q    <= '0;
							line_q   <= '0;
							seeded_q <= 1'b1;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_FAST;
							cnt_q   <= '0;
						end
					end
				end
				S_FAST, S_SLOW, S_SIG: begin
					if (cnt_q == '0) begin
						// Load dividend = 2|d| + floor(den/2).
						logic [PER_W:0] den;
						logic [DW-1:0]  tm;
						logic [DW:0]    dsum;
						den = '0;
						tm  = '0;
						if (state_q == S_FAST) begin
							den = {1'b0, pf_eff} + 1'b1;
							tm  = twice_mag(dfast);
							dneg_q <= dfast[AVG_W];
						end else if (state_q == S_SLOW) begin
							den = {1'b0, ps_eff} + 1'b1;
							tm  = twice_mag(dslow);
							dneg_q <= dslow[AVG_W];
						end else begin
							den = {1'b0, pg} + 1'b1;
							tm  = DW'(sig_d[SGW-1] ? -sig_d : sig_d) << 1;
							dneg_q <= sig_d[SGW-1];
						end
						dsum = {1'b0, tm} + (DW+1)'(den >> 1);
						dq_q   <= dsum[DW-1:0];
						dden_q <= den;
						drem_q <= '0;
						cnt_q  <= CW'(1);
					end else if (cnt_q <= CW'(DW)) begin
						dq_q   <= {dq_q[DW-2:0], dfit};
						drem_q <= dfit ? dsub[PER_W:0] : dtry[PER_W:0];
						cnt_q  <= cnt_q + 1'b1;
					end else begin
						cnt_q <= '0;
						if (state_q == S_FAST) begin
							fast_q  <= dneg_q ? fast_q - quo[AVG_W-1:0]
								: fast_q + quo[AVG_W-1:0];
							state_q <= S_SLOW;
						end else if (state_q == S_SLOW) begin
							slow_q  <= dneg_q ? slow_q - quo[AVG_W-1:0]
								: slow_q + quo[AVG_W-1:0];
							state_q <= S_LPREP;
						end else begin
							sig_q   <= dneg_q ? sig_q - SGW'(quo) : sig_q + SGW'(quo);
							state_q <= S_OUT;
						end
					end
				end
				S_LPREP: begin
					// Dividend |fast-slow| * 100 * 2^F, built by shifts and adds.
					logic [AVG_W-1:0] m;
					logic [LW:0]      lsum;
					m = (fast_q < slow_q) ? slow_q - fast_q : fast_q - slow_q;
					lneg_q <= fast_q < slow_q;
					lsum = ((LW+1)'(m) << (6 + FRAC_BITS)) + ((LW+1)'(m) << (5 + FRAC_BITS))
						+ ((LW+1)'(m) << (2 + FRAC_BITS));
					lq_q   <= lsum[LW-1:0];
					lrem_q <= '0;
					cnt_q  <= '0;
					if (slow_q == '0) begin
						line_q  <= '0;
						state_q <= S_SIG;
					end else
						state_q <= S_LINE;
				end
				S_LINE: begin
					lq_q   <= {lq_q[LW-2:0], lfit};
					lrem_q <= lfit ? RW'(ltry - {1'b0, slow_q}) : ltry[RW-1:0];
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CW'(LW - 1))
						state_q <= S_LFIN;
				end
				S_LFIN: begin
					// Saturate the truncated quotient and apply the sign.
					cnt_q <= '0;
					if (lneg_q) begin
						if (lq_q > LW'({1'b1, {(OUT_W-1){1'b0}}}))
							line_q <= {2'b11, {(OUT_W-1){1'b0}}};
						else
							line_q <= -signed'((OUT_W+1)'(lq_q));
					end else begin
						if (lq_q > LW'({(OUT_W-1){1'b1}}))
							line_q <= {2'b00, {(OUT_W-1){1'b1}}};
						else
							line_q <= (OUT_W+1)'(lq_q);
					end
					state_q <= S_SIG;
				end
				S_OUT: begin
					// Load the result word once the output register is free.
					if (!ovalid_q || out.ready) begin
						res_q.osc_line    <= line_q[OUT_W-1:0];
						res_q.signal_line <= sat(sig_q);
						res_q.histogram   <= sat(hist_w);
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input is only taken while idle.
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |-> state_q == S_IDLE)
		else $error("input taken while busy");
	// A held result is not overwritten.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(res_q))
		else $error("result lost under stall");
	// The line division never runs with a zero divisor.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINE |-> slow_q != '0)
		else $error("line division by zero");

endmodule

// File: bench/percentage_volume_oscillator_test.sv
//------------------------------------------------------------------------------
// percentage_volume_oscillator_test
// Drives volume words through the oscillator under several period settings
// and idling patterns, and checks every result word against a local predictor
// of the fast/slow volume averages, percentage line, signal and histogram.
//------------------------------------------------------------------------------
module percentage_volume_oscillator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pvo_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int WATCH_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;
	localparam longint POS_SAT = 64'sd2147483647;
	localparam longint NEG_SAT = -64'sd2147483648;
	// Index past the register list; writes to it are ignored.
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pvo_in_if  vol_ch();
	pvo_out_if res_ch();
	pvo_cfg_if cfg_ch();

	percentage_volume_oscillator DUT (
		.clk(clk), .arst_n(arst_n), .in(vol_ch.sink), .out(res_ch.source), .cfg(cfg_ch.sink)
	);

	always #5 clk = ~clk;

	// Predictor state and period registers.
	logic [PER_W-1:0] per_fast, per_slow, per_signal;
	longint avg_fast, avg_slow, avg_signal;
	bit primed;

	logic [VOL_W-1:0] pending_volumes[$];
	pvo_result_t expected_results[$];
	bit vol_taken = 1'b0;
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int idle_in_pct = 0;
	int stall_out_pct = 0;
	int quiet_cycles = 0;

	function automatic longint ema_step(longint avg, longint x, logic [PER_W-1:0] p);
		longint unsigned den, mag, q;
		longint d;
		den = longint'(p) + 1;
		d = x - avg;
		mag = (d < 0) ? -d : d;
		q = (2 * mag + den / 2) / den;
		return (d < 0) ? avg - longint'(q) : avg + longint'(q);
	endfunction

	function automatic longint saturate(longint v);
		if (v > POS_SAT) return POS_SAT;
		if (v < NEG_SAT) return NEG_SAT;
		return v;
	endfunction

	// Percentage of fast over slow, truncated toward zero, then saturated.
	function automatic longint pct_diff(longint fast_v, longint slow_v);
		bit neg;
		longint unsigned mag, den, ip, r, acc;
		if (slow_v <= 0) return 0;
		neg = fast_v < slow_v;
		mag = neg ? slow_v - fast_v : fast_v - slow_v;
		den = slow_v;
		ip = mag / den;
		if (ip > 64'h8000_0000) return neg ? NEG_SAT : POS_SAT;
		r = (mag % den) * 100;
		acc = ip * 100 + r / den;
		r = r % den;
		for (int i = 0; i < FB; i++) begin
			r = r << 1;
			acc = acc << 1;
			if (r >= den) begin
				r = r - den;
				acc = acc | 1;
			end
		end
		if (neg) return (acc > 64'h8000_0000) ? NEG_SAT : -longint'(acc);
		return (acc > 64'h7FFF_FFFF) ? POS_SAT : longint'(acc);
	endfunction

	function automatic logic [PER_W-1:0] eff_period(logic [PER_W-1:0] p);
		if (p == '0) return PER_W'(1);
		if (p > PERIOD_MAX) return PERIOD_MAX;
		return p;
	endfunction

	// Work out the result word that one volume word will give.
	function automatic pvo_result_t predict_pvo(logic [VOL_W-1:0] vol);
		pvo_result_t r;
		logic [PER_W-1:0] pf, ps, pg, t;
		longint x, line, sig_v, hist_v;
		pf = eff_period(per_fast);
		ps = eff_period(per_slow);
		pg = eff_period(per_signal);
		x = longint'({32'd0, vol}) << FB;
		if (pf > ps) begin
			t = pf; pf = ps; ps = t;
		end
		if (!primed) begin
			avg_fast = x;
			avg_slow = x;
			avg_signal = 0;
			primed = 1;
			return '0;
		end
		avg_fast = ema_step(avg_fast, x, pf);
		avg_slow = ema_step(avg_slow, x, ps);
		line = pct_diff(avg_fast, avg_slow);
		avg_signal = ema_step(avg_signal, line, pg);
		sig_v = saturate(avg_signal);
		hist_v = saturate(line - avg_signal);
		r.osc_line = line[31:0];
		r.signal_line = sig_v[31:0];
		r.histogram = hist_v[31:0];
		return r;
	endfunction

	// Driver: one volume word per handshake, with random idle cycles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!vol_ch.valid || vol_taken) begin
				if (pending_volumes.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
					vol_ch.valid <= 1'b1;
					vol_ch.volume <= pending_volumes[0];
				end else begin
					vol_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= ($urandom_range(99) >= stall_out_pct);
		end
	end

	// Monitor: predict on accepted volume words, check accepted result words.
	always @(posedge clk) begin
		pvo_result_t exp_r;
		vol_taken <= arst_n && vol_ch.valid && vol_ch.ready;
		if (arst_n) begin
			if (vol_ch.valid && vol_ch.ready) begin
				expected_results.push_back(predict_pvo(vol_ch.volume));
				void'(pending_volumes.pop_front());
				items_sent++;
			end
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%t: unexpected result word line=%0d signal=%0d hist=%0d",
						$realtime, res_ch.osc_line, res_ch.signal_line, res_ch.histogram);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (res_ch.osc_line !== exp_r.osc_line) begin
						$display("%t: osc_line expected %0d actual %0d", $realtime,
							exp_r.osc_line, res_ch.osc_line);
						errors++;
					end
					if (res_ch.signal_line !== exp_r.signal_line) begin
						$display("%t: signal_line expected %0d actual %0d", $realtime,
							exp_r.signal_line, res_ch.signal_line);
						errors++;
					end
					if (res_ch.histogram !== exp_r.histogram) begin
						$display("%t: histogram expected %0d actual %0d", $realtime,
							exp_r.histogram, res_ch.histogram);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no accepted word.
	always @(posedge clk) begin
		if ((vol_ch.valid && vol_ch.ready) || (res_ch.valid && res_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("Watchdog expired with %0d result words pending",
				expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_period(logic [IDX_W-1:0] idx, logic [PER_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_FAST:   per_fast = val;
			REG_SLOW:   per_slow = val;
			REG_SIGNAL: per_signal = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain_all();
		while (pending_volumes.size() > 0 || vol_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random volume: mostly a drifting level, sometimes extremes or noise.
	function automatic logic [VOL_W-1:0] random_volume(logic [VOL_W-1:0] base);
		case ($urandom_range(9))
			0: return $urandom();
			1: return 0;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(100);
			default: return base + $urandom_range(base / 4 + 10) - (base / 8 + 5);
		endcase
	endfunction

	initial begin
		logic [VOL_W-1:0] level;
		logic [VOL_W-1:0] directed[18] = '{32'd0, 32'd0, 32'd5, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
			32'd0, 32'd0, 32'd1000, 32'hFFFF_FFFF, 32'd1, 32'h5555_5555,
			32'hAAAA_AAAA, 32'd0};
		logic [PER_W-1:0] set_f[5] = '{1, 2047, 12, 1024, 3};
		logic [PER_W-1:0] set_s[5] = '{0, 1, 26, 1024, 700};
		logic [PER_W-1:0] set_g[5] = '{1, 0, 9, 1500, 1024};
		int idle_in[5] = '{0, 79, 0, 20, 0};
		int stall_out[5] = '{0, 0, 79, 20, 0};
		vol_ch.valid = 1'b0;
		vol_ch.volume = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		per_fast = FAST_RST;
		per_slow = SLOW_RST;
		per_signal = SIGNAL_RST;
		primed = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset periods, extremes, zero slow average, steps.
		foreach (directed[i])
			pending_volumes.push_back(directed[i]);
		drain_all();

		// Random phases, each under its own periods and idling pattern.
		for (int ph = 0; ph < 5; ph++) begin
			write_period(REG_FAST, set_f[ph]);
			write_period(REG_SLOW, set_s[ph]);
			write_period(REG_SIGNAL, set_g[ph]);
			write_period(REG_UNUSED, PER_W'($urandom()));
			idle_in_pct = idle_in[ph];
			stall_out_pct = stall_out[ph];
			level = $urandom();
			for (int n = 0; n < 190; n++) begin
				level = random_volume(level);
				pending_volumes.push_back(level);
			end
			drain_all();
		end

		$display("Covered %0d volume words and %0d result words over six period settings,",
			items_sent, results_seen);
		$display("with idle sender and stalled receiver phases.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
